// File: hdl/swd_pkg.sv
// Package: shared constants, codes and word types for the staleness watchdog.
package swd_pkg;

  // Table and datapath sizing
  localparam int NUM_VARS   = 64;
  localparam int TIME_BITS  = 32;
  localparam int VALUE_BITS = 64;
  localparam int ADDR_BITS  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

  // Field widths fixed by the interface
  localparam int IDX_W     = 6;
  localparam int SAMPLE_W  = 64;
  localparam int ELAPSED_W = 16;
  localparam int TMO_W     = 31;
  localparam int AGE_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Timeout reset values
  localparam logic [TMO_W-1:0] WARNING_TIMEOUT_RST  = TMO_W'(1000);
  localparam logic [TMO_W-1:0] FAULT_TIMEOUT_RST    = TMO_W'(1000);
  localparam logic [TMO_W-1:0] RECOVERY_TIMEOUT_RST = TMO_W'(500);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_SCAN   = 2'd2,
    OP_INIT   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    WS_NORMAL   = 2'd0,
    WS_WARNING  = 2'd1,
    WS_FAULT    = 2'd2,
    WS_RECOVERY = 2'd3
  } watch_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARNING_TIMEOUT  = 2'd0,
    CFG_FAULT_TIMEOUT    = 2'd1,
    CFG_RECOVERY_TIMEOUT = 2'd2
  } cfg_reg_t;

  // Input word
  typedef struct packed {
    opcode_t               opcode;
    logic [IDX_W-1:0]      var_index;
    logic [SAMPLE_W-1:0]   sample_value;
    logic [ELAPSED_W-1:0]  elapsed_ms;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    watch_state_t     watch_state;
    logic             state_changed;
    logic [AGE_W-1:0] since_last_ms;
  } out_word_t;

  // Timeout settings
  typedef struct packed {
    logic [TMO_W-1:0] warning_timeout;
    logic [TMO_W-1:0] fault_timeout;
    logic [TMO_W-1:0] recovery_timeout;
  } cfg_t;

  // One table row
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [TIME_BITS-1:0]  last_change;
    logic [TIME_BITS-1:0]  prior_change;
    watch_state_t          state;
    logic                  gap_valid;
  } row_t;

  // Scan evaluation result
  typedef struct packed {
    watch_state_t     next_state;
    logic             changed;
    logic [AGE_W-1:0] since_last_ms;
  } scan_t;

endpackage

// File: hdl/swd_rules.sv
// Scan rule evaluation: age, change gap and the prioritized state transitions.
module swd_rules (
  input  swd_pkg::cfg_t                       cfg,
  input  logic [swd_pkg::TIME_BITS-1:0]       now_ms,
  input  swd_pkg::row_t                       row,
  output swd_pkg::scan_t                      scan
);

  logic [swd_pkg::TIME_BITS-1:0] age;
  logic [swd_pkg::TIME_BITS-1:0] gap;
  logic [63:0]                   age_w;
  logic [63:0]                   gap_w;
  logic [63:0]                   fault_limit;
  logic                          past_warning;
  logic                          past_fault;
  logic                          recovering;
  swd_pkg::watch_state_t         next_state;

  // Modular ages, compared in a wide domain so no sum overflows
  always_comb begin
    age          = now_ms - row.last_change;
    gap          = row.last_change - row.prior_change;
    age_w        = 64'(age);
    gap_w        = 64'(gap);
    fault_limit  = 64'(cfg.warning_timeout) + 64'(cfg.fault_timeout);
    past_warning = age_w >= 64'(cfg.warning_timeout);
    past_fault   = age_w >= fault_limit;
    recovering   = row.gap_valid && (gap_w <= 64'(cfg.recovery_timeout));
  end

  // Transition rules, first match wins
  always_comb begin
    next_state = row.state;
    unique case (row.state)
      swd_pkg::WS_NORMAL: begin
        if (past_warning) next_state = swd_pkg::WS_WARNING;
      end
      swd_pkg::WS_WARNING: begin
        if (past_fault) next_state = swd_pkg::WS_FAULT;
        else if (recovering) next_state = swd_pkg::WS_RECOVERY;
      end
      swd_pkg::WS_FAULT: begin
        if (recovering) next_state = swd_pkg::WS_RECOVERY;
      end
      swd_pkg::WS_RECOVERY: begin
        if (past_warning) next_state = swd_pkg::WS_WARNING;
        else if (recovering) next_state = swd_pkg::WS_NORMAL;
      end
      default: next_state = row.state;
    endcase
  end

  // Report word with the age saturated to 32 bits
  always_comb begin
    scan.next_state    = next_state;
    scan.changed       = (next_state != row.state);
    scan.since_last_ms = (age_w > 64'hFFFF_FFFF) ? '1 : swd_pkg::AGE_W'(age_w);
  end

endmodule

// File: hdl/signal_staleness_watchdog.sv
// Top level: staleness watchdog with variable table, clock and result register.
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+-------------------------------
//  item in  | start, busy, item                  | taken when start & !busy
//  result   | result_valid, result               | one-cycle strobe, no stall
//  config   | cfg_we, cfg_index, cfg_data        | written when cfg_we is high
//
// One word per clock; busy never rises. Each word reads its table row at the
// accept edge, is evaluated the next cycle and written back at the edge after
// acceptance. A scan's result is registered at that same edge and sits on the ports
// for the cycle after it. A one-deep bypass covers a row written back on the same
// edge it is read. Reset restores the timeouts, zeroes the clock and marks every
// row as normal through per-row valid bits.
module signal_staleness_watchdog (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  swd_pkg::in_word_t               item,
  output logic                            result_valid,
  output swd_pkg::out_word_t              result,
  input  logic                            cfg_we,
  input  logic [swd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swd_pkg::TMO_W-1:0]       cfg_data
);

  localparam int AW = swd_pkg::ADDR_BITS;

  swd_pkg::cfg_t                  cfg;
  logic [swd_pkg::TIME_BITS-1:0]  now_ms;
  logic [swd_pkg::TIME_BITS-1:0]  now_ms_next;

  // Table storage and per-row valid bits
  swd_pkg::row_t                  table_mem [swd_pkg::NUM_VARS];
  logic [swd_pkg::NUM_VARS-1:0]   row_valid;
  swd_pkg::row_t                  rd_row;
  logic [AW-1:0]                  rd_addr;

  // Stage one registers
  logic                           s1_valid;
  swd_pkg::in_word_t              s1_item;
  logic                           fwd_hit;
  swd_pkg::row_t                  fwd_row;

  // Stage one logic
  logic [AW-1:0]                  s1_addr;
  logic                           s1_in_range;
  swd_pkg::row_t                  cur_row;
  swd_pkg::row_t                  wr_row;
  logic                           wr_en;
  swd_pkg::scan_t                 scan;
  logic                           res_en;

  assign busy    = 1'b0;
  assign rd_addr = AW'(item.var_index);
  assign s1_addr = AW'(s1_item.var_index);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warning_timeout  <= swd_pkg::WARNING_TIMEOUT_RST;
      cfg.fault_timeout    <= swd_pkg::FAULT_TIMEOUT_RST;
      cfg.recovery_timeout <= swd_pkg::RECOVERY_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swd_pkg::CFG_WARNING_TIMEOUT:  cfg.warning_timeout  <= cfg_data;
        swd_pkg::CFG_FAULT_TIMEOUT:    cfg.fault_timeout    <= cfg_data;
        swd_pkg::CFG_RECOVERY_TIMEOUT: cfg.recovery_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept stage: register the word and read its row
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      fwd_hit  <= wr_en && (s1_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    s1_item <= item;
    fwd_row <= wr_row;
    rd_row  <= table_mem[rd_addr];
  end

  // Current row: bypass the write-back of the last cycle, unwritten rows read normal
  always_comb begin
    cur_row = fwd_hit ? fwd_row : rd_row;
    if (!row_valid[s1_addr]) begin
      cur_row.state     = swd_pkg::WS_NORMAL;
      cur_row.gap_valid = 1'b0;
    end
  end

  assign s1_in_range = 32'(s1_item.var_index) < 32'(swd_pkg::NUM_VARS);

  swd_rules u_rules (
    .cfg    (cfg),
    .now_ms (now_ms),
    .row    (cur_row),
    .scan   (scan)
  );

  // Row update and clock advance
  always_comb begin
    wr_row      = cur_row;
    wr_en       = 1'b0;
    res_en      = 1'b0;
    now_ms_next = now_ms;
    if (s1_valid) begin
      case (s1_item.opcode)
        swd_pkg::OP_TICK: begin
          now_ms_next = now_ms + swd_pkg::TIME_BITS'(s1_item.elapsed_ms);
        end
        swd_pkg::OP_UPDATE: begin
          if (cur_row.value != swd_pkg::VALUE_BITS'(s1_item.sample_value)) begin
            wr_row.value        = swd_pkg::VALUE_BITS'(s1_item.sample_value);
            wr_row.prior_change = cur_row.last_change;
            wr_row.last_change  = now_ms;
            wr_row.gap_valid    = 1'b1;
            wr_en               = s1_in_range;
          end
        end
        swd_pkg::OP_SCAN: begin
          wr_row.state = scan.next_state;
          wr_en        = s1_in_range;
          res_en       = s1_in_range;
        end
        swd_pkg::OP_INIT: begin
          wr_row.value        = swd_pkg::VALUE_BITS'(s1_item.sample_value);
          wr_row.last_change  = now_ms;
          wr_row.prior_change = now_ms;
          wr_row.gap_valid    = 1'b0;
          wr_row.state        = swd_pkg::WS_NORMAL;
          wr_en               = s1_in_range;
        end
        default: ;
      endcase
    end
  end

  // Clock, valid bits and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms       <= '0;
      row_valid    <= '0;
      result_valid <= 1'b0;
    end else begin
      now_ms       <= now_ms_next;
      result_valid <= res_en;
      if (wr_en) row_valid[s1_addr] <= 1'b1;
    end
  end

  // Table write-back and result word
  always_ff @(posedge clk) begin
    if (wr_en) table_mem[s1_addr] <= wr_row;
    result.result_index  <= s1_item.var_index;
    result.watch_state   <= scan.next_state;
    result.state_changed <= scan.changed;
    result.since_last_ms <= scan.since_last_ms;
  end

endmodule
